// ===== rtl/char_lcd_nibble_bus_sequencer_assert.svh =====
// Assertion macros used by the sequencer back end.
// Each check samples on the rising clock edge and is off while reset is low.
`ifndef CHAR_LCD_NIBBLE_BUS_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_BUS_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMP(label, clk, rst_n, pre, post)
`define ASSERT_NXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== rtl/lcdnb_pkg.sv =====
package lcdnb_pkg;

    // Timer and register widths
    localparam int TIMER_WIDTH = 20;
    localparam int CFG_W       = 20;
    localparam int PULSE_W     = 8;
    localparam int CFG_IDX_W   = 2;

    typedef logic [TIMER_WIDTH-1:0] t_timer;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_UP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_GAP = 2'd3;

    // Configuration reset values
    localparam logic [PULSE_W-1:0] PULSE_RST     = 8'd4;
    localparam logic [CFG_W-1:0]   POWER_UP_RST  = 20'd15000;
    localparam logic [CFG_W-1:0]   LONG_GAP_RST  = 20'd5000;
    localparam logic [CFG_W-1:0]   SHORT_GAP_RST = 20'd100;

    // Input action codes
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_CMD    = 3'd1;
    localparam logic [2:0] ACT_DATA   = 3'd2;
    localparam logic [2:0] ACT_LOCATE = 3'd3;
    localparam logic [2:0] ACT_INIT   = 3'd4;

    // Display constants
    localparam logic [7:0] ROW1_OFFSET   = 8'h40;
    localparam logic [7:0] SET_DDRAM     = 8'h80;
    localparam logic [7:0] CMD_FUNC_SET  = 8'b0010_1000;
    localparam logic [7:0] CMD_CLEAR     = 8'b0000_0001;
    localparam logic [7:0] CMD_DISP_ON   = 8'b0000_1100;
    localparam logic [3:0] NIB_WAKE      = 4'b0011;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'b0010;

    // Init step numbers
    localparam logic [3:0] STEP_LAST_NIB = 4'd3;
    localparam logic [3:0] STEP_CMD0     = 4'd4;
    localparam logic [3:0] STEP_CMD2     = 4'd6;

    // Classified request kinds
    typedef enum logic [1:0] {
        K_TICK,
        K_BYTE,
        K_INIT
    } t_kind;

    // One queued request
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       sel;
        logic       busy;
    } t_req;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PWR,
        PH_IN_H,
        PH_IN_L,
        PH_GAP,
        PH_BF_H1,
        PH_BF_L1,
        PH_BF_H2,
        PH_BF_L2,
        PH_HI_H,
        PH_HI_L,
        PH_LO_H,
        PH_LO_L
    } t_phase;

    // Pin levels of one result beat, refused in the top bit
    typedef struct packed {
        logic       refused;
        logic       idle;
        logic       drv;
        logic [3:0] nib;
        logic       rd;
        logic       rs;
        logic       en;
    } t_pins;

    // Command byte sent at a given init step
    function automatic logic [7:0] init_cmd(input logic [3:0] step);
        logic [7:0] cmd;
        case (step)
            STEP_CMD0:     cmd = CMD_FUNC_SET;
            STEP_CMD2:     cmd = CMD_DISP_ON;
            default:       cmd = CMD_CLEAR;
        endcase
        return cmd;
    endfunction

    // Force a delay into 1 .. 2^TIMER_WIDTH-1
    function automatic t_timer clamp_delay(input logic [CFG_W-1:0] d);
        localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
        logic [CMP_W-1:0] wide_d;
        logic [CMP_W-1:0] tmax_w;
        t_timer           res;
        wide_d = CMP_W'(d);
        tmax_w = CMP_W'({TIMER_WIDTH{1'b1}});
        if (d == '0) begin
            res = t_timer'(1);
        end else if (wide_d > tmax_w) begin
            res = {TIMER_WIDTH{1'b1}};
        end else begin
            res = t_timer'(wide_d);
        end
        return res;
    endfunction

endpackage

// ===== rtl/lcdnb_fifo.sv =====
module lcdnb_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcdnb_pkg::t_req   i_req,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output lcdnb_pkg::t_req   o_req
);

    lcdnb_pkg::t_req r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            push;
    logic            pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_req   = r_mem[r_rd_ptr];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/lcdnb_front.sv =====
module lcdnb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_byte_value,
    input  logic [5:0]        i_column,
    input  logic              i_row,
    input  logic              i_busy_in,
    input  logic              i_pop,
    output logic              o_valid,
    output lcdnb_pkg::t_req   o_req
);

    lcdnb_pkg::t_req req;
    logic [7:0]      locate_byte;

    // Build the cursor address command
    assign locate_byte = (8'({2'b00, i_column}) + (i_row ? lcdnb_pkg::ROW1_OFFSET : 8'h00))
                         | lcdnb_pkg::SET_DDRAM;

    // Classify the action into tick, byte or init
    always_comb begin
        req.kind = lcdnb_pkg::K_TICK;
        req.data = i_byte_value;
        req.sel  = 1'b0;
        req.busy = i_busy_in;
        unique case (i_action)
            lcdnb_pkg::ACT_CMD: begin
                req.kind = lcdnb_pkg::K_BYTE;
            end
            lcdnb_pkg::ACT_DATA: begin
                req.kind = lcdnb_pkg::K_BYTE;
                req.sel  = 1'b1;
            end
            lcdnb_pkg::ACT_LOCATE: begin
                req.kind = lcdnb_pkg::K_BYTE;
                req.data = locate_byte;
            end
            lcdnb_pkg::ACT_INIT: begin
                req.kind = lcdnb_pkg::K_INIT;
            end
            default: begin
                req.kind = lcdnb_pkg::K_TICK;
            end
        endcase
    end

    // Queue between front and back
    lcdnb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_req   (req),
        .o_ready (o_ready),
        .i_pop   (i_pop),
        .o_valid (o_valid),
        .o_req   (o_req)
    );

endmodule

// ===== rtl/lcdnb_back.sv =====
`include "char_lcd_nibble_bus_sequencer_assert.svh"

module lcdnb_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lcdnb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lcdnb_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                i_q_valid,
    input  lcdnb_pkg::t_req                     i_q_req,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lcdnb_pkg::t_pins                    o_out
);

    // Configuration
    logic [lcdnb_pkg::PULSE_W-1:0] r_pulse;
    logic [lcdnb_pkg::CFG_W-1:0]   r_power_up;
    logic [lcdnb_pkg::CFG_W-1:0]   r_long_gap;
    logic [lcdnb_pkg::CFG_W-1:0]   r_short_gap;

    // Sequencer state
    lcdnb_pkg::t_phase r_phase,     n_phase;
    lcdnb_pkg::t_timer r_wait,      n_wait;
    logic [7:0]        r_held_byte, n_held_byte;
    logic              r_held_sel,  n_held_sel;
    logic [3:0]        r_init_step, n_init_step;
    logic              r_busy_seen, n_busy_seen;
    logic              n_refused;

    // Output register
    logic              r_out_valid;
    lcdnb_pkg::t_pins  r_out, n_out;

    lcdnb_pkg::t_timer pulse_d;
    lcdnb_pkg::t_timer power_d;
    lcdnb_pkg::t_timer long_d;
    lcdnb_pkg::t_timer short_d;

    assign pulse_d = lcdnb_pkg::clamp_delay(lcdnb_pkg::CFG_W'(r_pulse));
    assign power_d = lcdnb_pkg::clamp_delay(r_power_up);
    assign long_d  = lcdnb_pkg::clamp_delay(r_long_gap);
    assign short_d = lcdnb_pkg::clamp_delay(r_short_gap);

    // Take a queued beat whenever the output slot frees up
    assign o_q_pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse     <= lcdnb_pkg::PULSE_RST;
            r_power_up  <= lcdnb_pkg::POWER_UP_RST;
            r_long_gap  <= lcdnb_pkg::LONG_GAP_RST;
            r_short_gap <= lcdnb_pkg::SHORT_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lcdnb_pkg::REG_PULSE:     r_pulse     <= i_cfg_data[lcdnb_pkg::PULSE_W-1:0];
                lcdnb_pkg::REG_POWER_UP:  r_power_up  <= i_cfg_data;
                lcdnb_pkg::REG_LONG_GAP:  r_long_gap  <= i_cfg_data;
                lcdnb_pkg::REG_SHORT_GAP: r_short_gap <= i_cfg_data;
                default:                  r_pulse     <= r_pulse;
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lcdnb_pkg::PH_IDLE;
            r_wait      <= '0;
            r_held_byte <= '0;
            r_held_sel  <= 1'b0;
            r_init_step <= '0;
            r_busy_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase     <= n_phase;
                r_wait      <= n_wait;
                r_held_byte <= n_held_byte;
                r_held_sel  <= n_held_sel;
                r_init_step <= n_init_step;
                r_busy_seen <= n_busy_seen;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result beat
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

    // Next state for the beat at the queue head
    always_comb begin
        n_phase     = r_phase;
        n_wait      = r_wait;
        n_held_byte = r_held_byte;
        n_held_sel  = r_held_sel;
        n_init_step = r_init_step;
        n_busy_seen = r_busy_seen;
        n_refused   = 1'b0;

        if (i_q_req.kind != lcdnb_pkg::K_TICK) begin
            if (r_phase != lcdnb_pkg::PH_IDLE) begin
                // drop a request that arrives mid-sequence
                n_refused = 1'b1;
            end else if (i_q_req.kind == lcdnb_pkg::K_INIT) begin
                n_init_step = '0;
                n_phase     = lcdnb_pkg::PH_PWR;
                n_wait      = power_d;
            end else begin
                n_init_step = '0;
                n_held_byte = i_q_req.data;
                n_held_sel  = i_q_req.sel;
                n_busy_seen = 1'b0;
                n_phase     = lcdnb_pkg::PH_BF_H1;
                n_wait      = pulse_d;
            end
        end else if (r_phase != lcdnb_pkg::PH_IDLE) begin
            if (r_wait > lcdnb_pkg::t_timer'(1)) begin
                n_wait = r_wait - lcdnb_pkg::t_timer'(1);
            end else begin
                n_wait = pulse_d;
                unique case (r_phase)
                    lcdnb_pkg::PH_PWR:   n_phase = lcdnb_pkg::PH_IN_H;
                    lcdnb_pkg::PH_IN_H:  n_phase = lcdnb_pkg::PH_IN_L;
                    lcdnb_pkg::PH_IN_L: begin
                        if (r_init_step == 4'd0) begin
                            n_phase = lcdnb_pkg::PH_GAP;
                            n_wait  = long_d;
                        end else if (r_init_step < lcdnb_pkg::STEP_LAST_NIB) begin
                            n_phase = lcdnb_pkg::PH_GAP;
                            n_wait  = short_d;
                        end else begin
                            n_init_step = lcdnb_pkg::STEP_CMD0;
                            n_held_byte = lcdnb_pkg::init_cmd(lcdnb_pkg::STEP_CMD0);
                            n_held_sel  = 1'b0;
                            n_busy_seen = 1'b0;
                            n_phase     = lcdnb_pkg::PH_BF_H1;
                        end
                    end
                    lcdnb_pkg::PH_GAP: begin
                        n_init_step = r_init_step + 4'd1;
                        n_phase     = lcdnb_pkg::PH_IN_H;
                    end
                    lcdnb_pkg::PH_BF_H1: begin
                        n_busy_seen = i_q_req.busy;
                        n_phase     = lcdnb_pkg::PH_BF_L1;
                    end
                    lcdnb_pkg::PH_BF_L1: n_phase = lcdnb_pkg::PH_BF_H2;
                    lcdnb_pkg::PH_BF_H2: n_phase = lcdnb_pkg::PH_BF_L2;
                    lcdnb_pkg::PH_BF_L2: begin
                        n_phase = r_busy_seen ? lcdnb_pkg::PH_BF_H1 : lcdnb_pkg::PH_HI_H;
                    end
                    lcdnb_pkg::PH_HI_H:  n_phase = lcdnb_pkg::PH_HI_L;
                    lcdnb_pkg::PH_HI_L:  n_phase = lcdnb_pkg::PH_LO_H;
                    lcdnb_pkg::PH_LO_H:  n_phase = lcdnb_pkg::PH_LO_L;
                    lcdnb_pkg::PH_LO_L: begin
                        // chain the next init command or finish
                        if (r_init_step >= lcdnb_pkg::STEP_CMD0 &&
                            r_init_step < lcdnb_pkg::STEP_CMD2) begin
                            n_init_step = r_init_step + 4'd1;
                            n_held_byte = lcdnb_pkg::init_cmd(r_init_step + 4'd1);
                            n_held_sel  = 1'b0;
                            n_busy_seen = 1'b0;
                            n_phase     = lcdnb_pkg::PH_BF_H1;
                        end else begin
                            n_init_step = '0;
                            n_phase     = lcdnb_pkg::PH_IDLE;
                            n_wait      = '0;
                        end
                    end
                    default: begin
                        n_init_step = '0;
                        n_phase     = lcdnb_pkg::PH_IDLE;
                        n_wait      = '0;
                    end
                endcase
            end
        end
    end

    // Decode pin levels from the next phase
    always_comb begin
        n_out         = '0;
        n_out.drv     = 1'b1;
        n_out.idle    = (n_phase == lcdnb_pkg::PH_IDLE);
        n_out.refused = n_refused;
        unique case (n_phase)
            lcdnb_pkg::PH_IN_H, lcdnb_pkg::PH_IN_L, lcdnb_pkg::PH_GAP: begin
                n_out.nib = (n_init_step >= lcdnb_pkg::STEP_LAST_NIB) ?
                            lcdnb_pkg::NIB_FOUR_BIT : lcdnb_pkg::NIB_WAKE;
                n_out.en  = (n_phase == lcdnb_pkg::PH_IN_H);
            end
            lcdnb_pkg::PH_BF_H1, lcdnb_pkg::PH_BF_L1,
            lcdnb_pkg::PH_BF_H2, lcdnb_pkg::PH_BF_L2: begin
                n_out.rd  = 1'b1;
                n_out.drv = 1'b0;
                n_out.en  = (n_phase == lcdnb_pkg::PH_BF_H1) ||
                            (n_phase == lcdnb_pkg::PH_BF_H2);
            end
            lcdnb_pkg::PH_HI_H, lcdnb_pkg::PH_HI_L: begin
                n_out.rs  = n_held_sel;
                n_out.nib = n_held_byte[7:4];
                n_out.en  = (n_phase == lcdnb_pkg::PH_HI_H);
            end
            lcdnb_pkg::PH_LO_H, lcdnb_pkg::PH_LO_L: begin
                n_out.rs  = n_held_sel;
                n_out.nib = n_held_byte[3:0];
                n_out.en  = (n_phase == lcdnb_pkg::PH_LO_H);
            end
            default: begin
                n_out.en = 1'b0;
            end
        endcase
    end

    // A refused beat is never reported as idle
    `ASSERT_IMP(a_refused_not_idle, i_clk, i_rst_n, r_out_valid && r_out.refused, !r_out.idle)
    // The timer rests at zero while idle
    `ASSERT_IMP(a_idle_timer_zero, i_clk, i_rst_n, r_phase == lcdnb_pkg::PH_IDLE, r_wait == '0)
    // A request mid-sequence comes back refused
    `ASSERT_NXT(a_busy_refuses, i_clk, i_rst_n, o_q_pop && i_q_req.kind != lcdnb_pkg::K_TICK && r_phase != lcdnb_pkg::PH_IDLE, r_out_valid && r_out.refused)
    // The init step never runs past the last init command
    `ASSERT_IMP(a_step_range, i_clk, i_rst_n, 1'b1, r_init_step <= lcdnb_pkg::STEP_CMD2)

endmodule

// ===== rtl/char_lcd_nibble_bus_sequencer.sv =====
// A request beat accepted into the queue is popped into the output register, which presents
// its pin beat; beats already waiting in the queue are presented before it.
// Throughput: one beat per cycle when the pin stream does not stall; a stalled pin stream
// backs up through the two-entry queue to s_axis_tready.
// Reset: synchronous, active low; clears the queue, output register and sequencer,
// and loads the default delay registers. No clearing pass.
module char_lcd_nibble_bus_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [lcdnb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lcdnb_pkg::CFG_W-1:0]         i_cfg_data,
    // Request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // byte_value[7:0], column[13:8],
                                                               // row[14], busy_in[15]
    input  logic [2:0]                          s_axis_tuser,  // action[2:0]
    // Pin level stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata   // lcd_enable[0], lcd_select_data[1],
                                                               // lcd_read[2], lcd_nibble[6:3],
                                                               // drive_nibble[7], idle[8],
                                                               // refused[9]
);

    logic             q_pop;
    logic             q_valid;
    lcdnb_pkg::t_req  q_req;
    lcdnb_pkg::t_pins out_pins;

    // Classify requests and queue them
    lcdnb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_byte_value (s_axis_tdata[7:0]),
        .i_column     (s_axis_tdata[13:8]),
        .i_row        (s_axis_tdata[14]),
        .i_busy_in    (s_axis_tdata[15]),
        .i_pop        (q_pop),
        .o_valid      (q_valid),
        .o_req        (q_req)
    );

    // Run the pin sequence
    lcdnb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (out_pins)
    );

    assign m_axis_tdata = {6'b000000, out_pins};

endmodule
